@@ rtl/aes_pkg.sv @@
// Package for the AES block encryption pipeline: types, S-box and round helpers.
package aes_pkg;

  localparam int unsigned RoundsDef = 10;
  localparam int unsigned SlotW     = 5;
  localparam int unsigned HalfW     = 64;
  localparam int unsigned BlockW    = 128;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ENCRYPT = 1'b1
  } op_e;

  typedef logic [7:0] sbox_t [256];

  localparam sbox_t SBOX = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the state is bits [127-8i -: 8]; byte i sits at row i%4, column i/4
  function automatic logic [BlockW-1:0] sub_shift(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(r+4*c) -: 8] = SBOX[s[BlockW-1-8*(r+4*((c+r)%4)) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [BlockW-1:0] mix_columns(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[BlockW-1-32*c -: 8];
      a1 = s[BlockW-9-32*c -: 8];
      a2 = s[BlockW-17-32*c -: 8];
      a3 = s[BlockW-25-32*c -: 8];
      t[BlockW-1-32*c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[BlockW-9-32*c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[BlockW-17-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[BlockW-25-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_columns = t;
  endfunction

endpackage

@@ rtl/aes128_encrypt_block.sv @@
// AES block encryption: one pipeline stage per round, round keys held in registers.
//
// A block can enter on every cycle that the input side is ready. Its ciphertext passes
// through one key-add stage, then one stage per round, before it reaches the output.
// The last round stage drives the output directly. Throughput is one block per clock,
// set by the unrolled round stages. The whole pipeline advances together and stalls
// while the output is not taken. Load items write a round key half into the key registers
// and produce no output. A load is held off while any encryption still has rounds to go,
// so blocks already in the pipe finish with the keys they entered with. A load that
// follows encryptions waits until the last one reaches the final stage, longer if output stalls.
module aes128_encrypt_block
  import aes_pkg::*;
#(
  parameter int unsigned ROUNDS = RoundsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [HalfW+HalfW+7:0] s_axis_tdata_i,  // key_slot[4:0], block_hi, block_lo, zero pad
  input  logic                  s_axis_tuser_i,   // opcode
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [BlockW-1:0]     m_axis_tdata_o    // cipher_hi, cipher_lo
);

  localparam int unsigned Slots = 2 * (ROUNDS + 1);

  logic [HalfW-1:0] key_q [Slots];
  logic [BlockW-1:0] st_q [ROUNDS+1];
  logic [ROUNDS:0]   vld_q;
  logic              adv;
  logic              load_hold;
  logic              in_fire;

  logic [SlotW-1:0]  slot;
  logic [HalfW-1:0]  in_hi, in_lo;
  op_e               op;

  assign slot  = s_axis_tdata_i[SlotW-1:0];
  assign in_hi = s_axis_tdata_i[SlotW +: HalfW];
  assign in_lo = s_axis_tdata_i[SlotW+HalfW +: HalfW];
  assign op    = op_e'(s_axis_tuser_i);

  // keys must stay stable for blocks that still read them
  assign load_hold       = s_axis_tvalid_i && op == OP_LOAD && (|vld_q[ROUNDS-1:0]);
  assign adv             = !vld_q[ROUNDS] || m_axis_tready_i;
  assign s_axis_tready_o = adv && !load_hold;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = vld_q[ROUNDS];
  assign m_axis_tdata_o  = {st_q[ROUNDS][HalfW-1:0], st_q[ROUNDS][BlockW-1:HalfW]};

  function automatic logic [BlockW-1:0] rkey(input int r);
    rkey = {key_q[2*r], key_q[2*r+1]};
  endfunction

  always_ff @(posedge clk_i) begin
    if (in_fire && op == OP_LOAD && 32'(slot) < Slots) begin
      key_q[slot] <= in_hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[ROUNDS-1:0], in_fire && op == OP_ENCRYPT};
    end
  end

  // stage 0: initial key add; stage r: round r
  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= {in_hi, in_lo} ^ rkey(0);
      for (int r = 1; r < ROUNDS; r++) begin
        st_q[r] <= mix_columns(sub_shift(st_q[r-1])) ^ rkey(r);
      end
      st_q[ROUNDS] <= sub_shift(st_q[ROUNDS-1]) ^ rkey(ROUNDS);
    end
  end

endmodule
